// File: sv/hex_text_to_byte_decoder_top_assert.svh
// Assertion macros for the hex text decoder RTL.
`ifndef HEX_TEXT_TO_BYTE_DECODER_TOP_ASSERT_SVH
`define HEX_TEXT_TO_BYTE_DECODER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define HEXD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define HEXD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define HEXD_ASSERT(label, prop, msg)
`define HEXD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: sv/hexd_pkg.sv
// Shared types, codes and digit decoding for the hex text decoder.
package hexd_pkg;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic SEP_ENABLE_RESET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_NO_SEP    = 2'd2,
    ST_LENGTH    = 2'd3
  } status_e;

  // Position inside a byte group.
  typedef enum logic [2:0] {
    POS_HIGH = 3'b001,
    POS_LOW  = 3'b010,
    POS_SEP  = 3'b100
  } pos_e;

  typedef struct packed {
    pos_e       pos;
    logic [3:0] high_nibble;
    status_e    err;
  } state_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    status_e    status;
    logic       end_out;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  localparam state_t STATE_RESET = '{pos: POS_HIGH, high_nibble: 4'd0, err: ST_OK};

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    logic [7:0] diff;
    d    = '{ok: 1'b0, value: 4'd0};
    diff = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      diff = c - CHAR_0;
      d    = '{ok: 1'b1, value: diff[3:0]};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      diff = c - CHAR_UA + 8'd10;
      d    = '{ok: 1'b1, value: diff[3:0]};
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      diff = c - CHAR_LA + 8'd10;
      d    = '{ok: 1'b1, value: diff[3:0]};
    end
    return d;
  endfunction

endpackage

// File: sv/hexd_step.sv
// Next-state and result logic for one character of hex text.
module hexd_step (
  input  hexd_pkg::state_t  state_i,
  input  logic              sep_en_i,
  input  logic [7:0]        text_char_i,
  input  logic              end_of_text_i,
  output hexd_pkg::state_t  state_o,
  output hexd_pkg::result_t result_o
);

  hexd_pkg::digit_t dig;
  hexd_pkg::state_t nxt;
  hexd_pkg::pos_e   want;
  logic             valid;
  logic [7:0]       data;

  assign dig = hexd_pkg::hex_digit(text_char_i);

  always_comb begin
    nxt   = state_i;
    valid = 1'b0;
    data  = 8'd0;
    want  = sep_en_i ? hexd_pkg::POS_SEP : hexd_pkg::POS_HIGH;
    if (state_i.err == hexd_pkg::ST_OK) begin
      unique case (state_i.pos)
        hexd_pkg::POS_SEP: begin
          if (text_char_i == hexd_pkg::CHAR_SPACE) begin
            nxt.pos = hexd_pkg::POS_HIGH;
          end else begin
            nxt.err = hexd_pkg::ST_NO_SEP;
          end
        end
        hexd_pkg::POS_LOW: begin
          if (dig.ok) begin
            valid   = 1'b1;
            data    = {state_i.high_nibble, dig.value};
            nxt.pos = want;
          end else begin
            nxt.err = hexd_pkg::ST_BAD_DIGIT;
          end
        end
        default: begin
          if (dig.ok) begin
            nxt.high_nibble = dig.value;
            nxt.pos         = hexd_pkg::POS_LOW;
          end else begin
            nxt.err = hexd_pkg::ST_BAD_DIGIT;
          end
        end
      endcase
      // the string must end right after a completed pair
      if (nxt.err == hexd_pkg::ST_OK && end_of_text_i &&
          (nxt.pos != want || !valid)) begin
        nxt.err = hexd_pkg::ST_LENGTH;
      end
    end
    result_o = '{byte_valid: valid, data_byte: data, status: nxt.err,
                 end_out: end_of_text_i};
    state_o  = end_of_text_i ? hexd_pkg::STATE_RESET : nxt;
  end

endmodule

// File: sv/hex_text_to_byte_decoder_top.sv
// Top level of the hex text to byte decoder.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o | text_char_i, end_of_text_i
//   out     | out_valid_o/ out_stall_i| byte_valid_o, data_byte_o, status_o, end_out_o
//   cfg     | cfg_valid_i/ cfg_ready_o| cfg_separator_enable_i
//
// One character per cycle while in_stall_o is low; its result is registered and shows in the next cycle.
// The only loop is the position/nibble/error state register, updated on each accepted character.
// The result register holds a request while out_stall_i is high; input stalls only
// then, and a new character is taken in the same cycle the held result leaves.
// Reset: separator mode on, position at high digit, no error, output empty.
module hex_text_to_byte_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       byte_valid_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] status_o,
  output logic       end_out_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_separator_enable_i
);

  `include "hex_text_to_byte_decoder_top_assert.svh"

  hexd_pkg::state_t  state_q, state_d;
  hexd_pkg::result_t result_q, result_d;
  logic              sep_en_q;
  logic              out_valid_q;
  logic              in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  hexd_step u_step (
    .state_i       (state_q),
    .sep_en_i      (sep_en_q),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_en_q    <= hexd_pkg::SEP_ENABLE_RESET;
      state_q     <= hexd_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        sep_en_q <= cfg_separator_enable_i;
      end
      if (in_acc) begin
        state_q <= state_d;
      end
      // advance when a new request comes in, drop once the held one is taken
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_valid_o = result_q.byte_valid;
  assign data_byte_o  = result_q.data_byte;
  assign status_o     = result_q.status;
  assign end_out_o    = result_q.end_out;

  `HEXD_ASSERT(a_byte_only_ok, out_valid_o && byte_valid_o |-> status_o == hexd_pkg::ST_OK, "byte with error status")
  `HEXD_ASSERT(a_no_byte_zero, out_valid_o && !byte_valid_o |-> data_byte_o == 8'd0, "data without byte")
  `HEXD_ASSERT(a_length_at_end, out_valid_o && status_o == hexd_pkg::ST_LENGTH |-> end_out_o, "length error before end")
  `HEXD_ASSERT(a_end_clears, in_acc && end_of_text_i |=> state_q == hexd_pkg::STATE_RESET, "state not cleared at end")
  `HEXD_ASSERT(a_err_latched, in_acc && !end_of_text_i && state_q.err != hexd_pkg::ST_OK |=> state_q.err == $past(state_q.err), "latched error changed")

endmodule
